// File: rtl/fmse_pkg.sv
`timescale 1ns / 1ps

package fmse_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [1:0] KIND_FILLER = 2'd0;
  localparam logic [1:0] KIND_MARK   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;
  localparam logic [1:0] KIND_EMIT   = 2'd3;

  localparam logic [7:0]  MARK_IDAM  = 8'hFE;
  localparam logic [7:0]  MARK_DAM   = 8'hFB;
  localparam logic [7:0]  MARK_DDAM  = 8'hF8;
  localparam logic [7:0]  MARK_IAM   = 8'hFC;
  localparam logic [15:0] CELLS_IDAM = 16'hF57E;
  localparam logic [15:0] CELLS_DAM  = 16'hF56F;
  localparam logic [15:0] CELLS_DDAM = 16'hF56A;
  localparam logic [15:0] CELLS_IAM  = 16'hF77A;

  typedef struct packed {
    logic       upd;
    logic       restart;
    logic [7:0] data;
  } crc_ctl_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] fm_cells(logic [7:0] b);
    logic [15:0] w;
    for (int i = 0; i < 8; i++) begin
      w[2*i+1] = 1'b1;
      w[2*i]   = b[i];
    end
    return w;
  endfunction

endpackage

// File: rtl/fmse_crc.sv
`timescale 1ns / 1ps

module fmse_crc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmse_pkg::crc_ctl_t ctl_i,
  output logic [15:0]        crc_o
);
  import fmse_pkg::*;

  logic [15:0] crc_q, crc_d, base;

  assign base  = ctl_i.restart ? CRC_INIT : crc_q;
  assign crc_d = ctl_i.upd ? crc_fold(base, ctl_i.data) : crc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// File: rtl/fmse_cell_enc.sv
`timescale 1ns / 1ps

module fmse_cell_enc (
  input  logic [1:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        phase_i,
  input  logic [15:0] crc_i,
  output logic [15:0] cell_word_o,
  output logic        last_o
);
  import fmse_pkg::*;

  logic [7:0]  enc_byte;
  logic [15:0] plain;
  logic [15:0] mark;

  always_comb begin
    if (kind_i == KIND_EMIT) begin
      enc_byte = phase_i ? crc_i[7:0] : crc_i[15:8];
    end else begin
      enc_byte = data_byte_i;
    end
  end

  assign plain = fm_cells(enc_byte);

  always_comb begin
    unique case (data_byte_i)
      MARK_IDAM: mark = CELLS_IDAM;
      MARK_DAM:  mark = CELLS_DAM;
      MARK_DDAM: mark = CELLS_DDAM;
      MARK_IAM:  mark = CELLS_IAM;
      default:   mark = plain;
    endcase
  end

  assign cell_word_o = (kind_i == KIND_MARK) ? mark : plain;
  assign last_o      = (kind_i != KIND_EMIT) || phase_i;

endmodule

// File: rtl/fm_sector_stream_encoder.sv
`timescale 1ns / 1ps
// An accepted beat passes from the input register, via the encoder, into the output register.
// Throughput: one byte beat per cycle while not stalled; an emit CRC beat holds the input
// register for both its output words; the output register sends one word per unstalled cycle.
// Reset (rst_ni low, asynchronous): both stages empty, emit phase cleared, CRC set to FFFF.
module fm_sector_stream_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_kind_i,
  input  logic [7:0]  in_data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_cell_word_o,
  output logic        out_last_o
);
  import fmse_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_kind_q;
  logic [7:0]  in_byte_q;
  logic        phase_q, phase_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_word_q;
  logic        out_last_q;

  logic        out_adv, fire, release_in, in_take;
  logic [15:0] enc_word, crc;
  logic        enc_last;
  crc_ctl_t    crc_ctl;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_adv;
  assign release_in = fire && ((in_kind_q != KIND_EMIT) || phase_q);
  assign in_stall_o = in_valid_q && !release_in;
  assign in_take    = in_valid_i && !in_stall_o;

  assign crc_ctl.upd     = fire && ((in_kind_q == KIND_MARK) || (in_kind_q == KIND_DATA));
  assign crc_ctl.restart = (in_kind_q == KIND_MARK);
  assign crc_ctl.data    = in_byte_q;

  fmse_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .crc_o  (crc)
  );

  fmse_cell_enc u_enc (
    .kind_i      (in_kind_q),
    .data_byte_i (in_byte_q),
    .phase_i     (phase_q),
    .crc_i       (crc),
    .cell_word_o (enc_word),
    .last_o      (enc_last)
  );

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (release_in ? 1'b0 : in_valid_q);
    phase_d    = phase_q;
    if (fire && (in_kind_q == KIND_EMIT)) begin
      phase_d = !phase_q;
    end
    out_valid_d = out_adv ? fire : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q <= in_kind_i;
      in_byte_q <= in_data_byte_i;
    end
    if (fire) begin
      out_word_q <= enc_word;
      out_last_q <= enc_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_cell_word_o = out_word_q;
  assign out_last_o      = out_last_q;

endmodule

// File: rtl/fmse_checker.sv
`timescale 1ns / 1ps

module fmse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] out_cell_word_o,
  input logic        out_last_o
);

  // hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_cell_word_o)
                                   && $stable(out_last_o))
    else $error("stalled output beat changed");

  // CRC low word follows the high word straight away
  a_emit_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=> out_valid_o && out_last_o)
    else $error("CRC low word missing after high word");

  // CRC high word always carries every clock cell
  a_emit_clocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> (out_cell_word_o & 16'hAAAA) == 16'hAAAA)
    else $error("CRC word missing clock cells");

  // drop output valid during reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind fm_sector_stream_encoder fmse_checker u_fmse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_cell_word_o (out_cell_word_o),
  .out_last_o      (out_last_o)
);
